// File: design/fss_pkg.sv
// Shared types, codes and field layout for the flight setpoint supervisor.
package fss_pkg;

    localparam int TIME_W    = 32;
    localparam int POS_W     = 32;
    localparam int QUAT_W    = 16;
    localparam int RADIUS_W  = 31;
    localparam int HEIGHT_W  = 31;
    localparam int FUNC_W    = 3;
    localparam int CMD_W     = 2;
    localparam int FSM_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Input word: now_time, stamp, pos x/y/z, quat w/x/y/z, offboard
    localparam int IN_BITS = 2 * TIME_W + 3 * POS_W + 4 * QUAT_W + 1;
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
    // Output word: sp x/y/z, sp q w/x/y/z, sequence, fsm state, command
    localparam int OUT_BITS = 3 * POS_W + 4 * QUAT_W + TIME_W + FSM_W + CMD_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_POS_SP  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ATT_SP  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POSE    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MODE    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PUBLISH = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CHECKUP = 3'd5;

    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKEOFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LAND    = 2'd2;

    localparam logic [FSM_W-1:0] FSM_STARTUP = 2'd0;
    localparam logic [FSM_W-1:0] FSM_LINKED  = 2'd1;
    localparam logic [FSM_W-1:0] FSM_HOVER   = 2'd2;
    localparam logic [FSM_W-1:0] FSM_ACTIVE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HOVER_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_RADIUS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_TAKEOFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAND_ENABLE  = 3'd4;

    typedef enum logic [3:0] {
        ST_STARTUP = 4'b0001,
        ST_LINKED  = 4'b0010,
        ST_HOVER   = 4'b0100,
        ST_ACTIVE  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        SS_INIT = 2'd0,
        SS_ON   = 2'd1,
        SS_OFF  = 2'd2
    } stream_t;

    function automatic logic [FSM_W-1:0] state_code(state_t s);
        logic [FSM_W-1:0] c;
        case (s)
            ST_STARTUP: c = FSM_STARTUP;
            ST_LINKED:  c = FSM_LINKED;
            ST_HOVER:   c = FSM_HOVER;
            ST_ACTIVE:  c = FSM_ACTIVE;
            default:    c = FSM_STARTUP;
        endcase
        return c;
    endfunction

endpackage

// File: design/flight_setpoint_supervisor.sv
// Flight setpoint supervisor: input register, one-pass update logic, result register.
// Words wait in the input register; any result goes into the output register.
// Throughput: one word per cycle; s_tready drops only while the input register is full and
// the output register holds a result that m_tready has not taken.
// One update pass per item; the safe-ball check (three 31x31 squarings) sets the path.
// Reset sets startup mode, stream statuses init, and stamps, poses and tick count zero.
module flight_setpoint_supervisor
    import fss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // now_time, stamp, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, offboard
    input  logic [IN_W-1:0]      s_tdata,
    // func
    input  logic [FUNC_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // sp_x, sp_y, sp_z, sp_qw, sp_qx, sp_qy, sp_qz, sequence_res, fsm_state, command
    output logic [OUT_W-1:0]     m_tdata,
    // publish_valid
    output logic [0:0]           m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int SQ_W  = 2 * RADIUS_W;
    localparam int SUM_W = SQ_W + 2;

    // configuration
    logic [HEIGHT_W-1:0] hover_height_reg;
    logic [RADIUS_W-1:0] safe_radius_reg;
    logic [SQ_W-1:0]     radius_sq_reg;
    logic [TIME_W-1:0]   stale_limit_reg;
    logic                skip_takeoff_reg;
    logic                land_enable_reg;

    // input stage
    logic                s1_valid_reg;
    logic [IN_W-1:0]     s1_data_reg;
    logic [FUNC_W-1:0]   s1_func_reg;

    // supervisor state
    state_t              mode_reg, mode_next;
    stream_t             pose_ss_reg, pose_ss_next;
    stream_t             ob_ss_reg, ob_ss_next;
    stream_t             sp_ss_reg, sp_ss_next;
    logic [TIME_W-1:0]   stamp_reg [3];
    logic [TIME_W-1:0]   stamp_next [3];
    logic [POS_W-1:0]    tgt_pos_reg [3];
    logic [POS_W-1:0]    tgt_pos_next [3];
    logic [QUAT_W-1:0]   tgt_q_reg [4];
    logic [QUAT_W-1:0]   tgt_q_next [4];
    logic [POS_W-1:0]    cur_pos_reg [3];
    logic [POS_W-1:0]    cur_pos_next [3];
    logic [QUAT_W-1:0]   cur_q_reg [4];
    logic [QUAT_W-1:0]   cur_q_next [4];
    logic [POS_W-1:0]    sav_pos_reg [3];
    logic [POS_W-1:0]    sav_pos_next [3];
    logic [QUAT_W-1:0]   sav_q_reg [4];
    logic [QUAT_W-1:0]   sav_q_next [4];
    logic [POS_W-1:0]    lpp_reg [3];
    logic [POS_W-1:0]    lpp_next [3];
    logic [TIME_W-1:0]   tick_reg, tick_next;

    // output stage
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;
    logic                out_pub_reg, out_pub_next;

    // unpacked input word
    logic [TIME_W-1:0]   in_now;
    logic [TIME_W-1:0]   in_stamp;
    logic [POS_W-1:0]    in_pos [3];
    logic [QUAT_W-1:0]   in_q [4];
    logic                in_offboard;

    logic                advance;
    logic                fire;

    // checkup helpers
    logic [TIME_W-1:0]       age [3];
    logic [2:0]              fresh;
    logic signed [POS_W:0]   diff [3];
    logic [POS_W:0]          adiff [3];
    logic [2:0]              far;
    logic [SQ_W-1:0]         sq [3];
    logic [SUM_W-1:0]        dist_sum;
    logic                    outside;

    // publish helpers
    logic [POS_W-1:0]    pub_pos [3];
    logic [QUAT_W-1:0]   pub_q [4];
    logic [CMD_W-1:0]    cmd;
    logic [CMD_W-1:0]    land_cmd;
    logic                ep_on, ep_off, ob_on, ob_off, sp_on, sp_off;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign fire     = s1_valid_reg && advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_pub_reg;

    assign in_now      = s1_data_reg[TIME_W-1:0];
    assign in_stamp    = s1_data_reg[2*TIME_W-1:TIME_W];
    assign in_offboard = s1_data_reg[IN_BITS-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_pos[i] = s1_data_reg[2*TIME_W + i*POS_W +: POS_W];
        end
        for (int i = 0; i < 4; i++)
        begin
            in_q[i] = s1_data_reg[2*TIME_W + 3*POS_W + i*QUAT_W +: QUAT_W];
        end
    end

    assign land_cmd = land_enable_reg ? CMD_LAND : CMD_NONE;
    assign ep_on  = (pose_ss_reg == SS_ON);
    assign ep_off = (pose_ss_reg == SS_OFF);
    assign ob_on  = (ob_ss_reg == SS_ON);
    assign ob_off = (ob_ss_reg == SS_OFF);
    assign sp_on  = (sp_ss_reg == SS_ON);
    assign sp_off = (sp_ss_reg == SS_OFF);

    // stream ages and safe-ball distance against the last published position
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            age[i]   = in_now - stamp_reg[i];
            fresh[i] = (age[i] < stale_limit_reg);
            diff[i]  = $signed({cur_pos_reg[i][POS_W-1], cur_pos_reg[i]})
                     - $signed({lpp_reg[i][POS_W-1], lpp_reg[i]});
            adiff[i] = diff[i][POS_W] ? (~diff[i] + 1'b1) : diff[i];
            far[i]   = (adiff[i] > {2'b00, safe_radius_reg});
            // exact when no axis is far, since then each distance fits the radius width
            sq[i]    = {{RADIUS_W{1'b0}}, adiff[i][RADIUS_W-1:0]}
                     * {{RADIUS_W{1'b0}}, adiff[i][RADIUS_W-1:0]};
        end
        dist_sum = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
        outside  = (|far) || (dist_sum > {2'b00, radius_sq_reg});
    end

    // publish pose selection and mode transitions
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sav_pos_next[i] = sav_pos_reg[i];
            pub_pos[i]      = sav_pos_reg[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            sav_q_next[i] = sav_q_reg[i];
            pub_q[i]      = sav_q_reg[i];
        end
        if (s1_func_reg == FN_PUBLISH)
        begin
            case (mode_reg)
                ST_ACTIVE:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sav_pos_next[i] = cur_pos_reg[i];
                        pub_pos[i]      = tgt_pos_reg[i];
                    end
                    for (int i = 0; i < 4; i++)
                    begin
                        sav_q_next[i] = cur_q_reg[i];
                        pub_q[i]      = tgt_q_reg[i];
                    end
                end
                ST_HOVER:
                begin
                    sav_pos_next[2] = {1'b0, hover_height_reg};
                    pub_pos[2]      = {1'b0, hover_height_reg};
                end
                default:
                begin
                    // hold the vehicle on the ground under its current pose
                    for (int i = 0; i < 3; i++)
                    begin
                        sav_pos_next[i] = (i == 2) ? '0 : cur_pos_reg[i];
                        pub_pos[i]      = (i == 2) ? '0 : cur_pos_reg[i];
                    end
                    for (int i = 0; i < 4; i++)
                    begin
                        sav_q_next[i] = cur_q_reg[i];
                        pub_q[i]      = cur_q_reg[i];
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        pose_ss_next   = pose_ss_reg;
        ob_ss_next     = ob_ss_reg;
        sp_ss_next     = sp_ss_reg;
        tick_next      = tick_reg;
        cmd            = CMD_NONE;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_pub_next   = out_pub_reg;
        for (int i = 0; i < 3; i++)
        begin
            stamp_next[i]   = stamp_reg[i];
            tgt_pos_next[i] = tgt_pos_reg[i];
            cur_pos_next[i] = cur_pos_reg[i];
            lpp_next[i]     = lpp_reg[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            tgt_q_next[i] = tgt_q_reg[i];
            cur_q_next[i] = cur_q_reg[i];
        end

        if (advance)
        begin
            out_valid_next = 1'b0;
        end

        if (fire)
        begin
            case (s1_func_reg)
                FN_POS_SP:
                begin
                    sp_ss_next    = SS_ON;
                    stamp_next[0] = in_stamp;
                    for (int i = 0; i < 3; i++)
                    begin
                        tgt_pos_next[i] = in_pos[i];
                    end
                end
                FN_ATT_SP:
                begin
                    sp_ss_next    = SS_ON;
                    stamp_next[1] = in_stamp;
                    for (int i = 0; i < 4; i++)
                    begin
                        tgt_q_next[i] = in_q[i];
                    end
                end
                FN_POSE:
                begin
                    stamp_next[2] = in_stamp;
                    for (int i = 0; i < 3; i++)
                    begin
                        cur_pos_next[i] = in_pos[i];
                    end
                    for (int i = 0; i < 4; i++)
                    begin
                        cur_q_next[i] = in_q[i];
                    end
                end
                FN_MODE:
                begin
                    ob_ss_next = in_offboard ? SS_ON : SS_OFF;
                end
                FN_CHECKUP:
                begin
                    if (!fresh[0] && !fresh[1])
                    begin
                        sp_ss_next = SS_OFF;
                    end
                    pose_ss_next = fresh[2] ? SS_ON : SS_OFF;
                    if (outside)
                    begin
                        // forced landing word carries no pose
                        mode_next      = ST_STARTUP;
                        out_valid_next = 1'b1;
                        out_pub_next   = 1'b0;
                        out_data_next  = '0;
                        out_data_next[OUT_BITS-1 -: CMD_W] = land_cmd;
                    end
                end
                FN_PUBLISH:
                begin
                    case (mode_reg)
                        ST_STARTUP:
                        begin
                            if (ep_on && ob_off)
                            begin
                                mode_next = ST_LINKED;
                            end
                        end
                        ST_LINKED:
                        begin
                            if (ep_off)
                            begin
                                cmd       = land_cmd;
                                mode_next = ST_STARTUP;
                            end
                            else if (ep_on && ob_on && sp_off)
                            begin
                                cmd       = skip_takeoff_reg ? CMD_NONE : CMD_TAKEOFF;
                                mode_next = ST_HOVER;
                            end
                        end
                        ST_HOVER:
                        begin
                            if (ep_off)
                            begin
                                cmd       = land_cmd;
                                mode_next = ST_STARTUP;
                            end
                            else if (ep_on && ob_off)
                            begin
                                cmd       = land_cmd;
                                mode_next = ST_LINKED;
                            end
                            else if (ep_on && ob_on && sp_on)
                            begin
                                mode_next = ST_ACTIVE;
                            end
                        end
                        default:
                        begin
                            if (ep_on && ob_off)
                            begin
                                cmd       = land_cmd;
                                mode_next = ST_LINKED;
                            end
                            else if (ep_on && ob_on && sp_off)
                            begin
                                mode_next = ST_HOVER;
                            end
                            else if (ep_off)
                            begin
                                cmd       = land_cmd;
                                mode_next = ST_STARTUP;
                            end
                        end
                    endcase
                    for (int i = 0; i < 3; i++)
                    begin
                        lpp_next[i] = pub_pos[i];
                    end
                    tick_next      = tick_reg + 1'b1;
                    out_valid_next = 1'b1;
                    out_pub_next   = 1'b1;
                    out_data_next  = {{(OUT_W - OUT_BITS){1'b0}}, cmd, state_code(mode_next),
                                      tick_reg, pub_q[3], pub_q[2], pub_q[1], pub_q[0],
                                      pub_pos[2], pub_pos[1], pub_pos[0]};
                end
                default:
                begin
                    // unused codes: drop the word
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hover_height_reg <= HEIGHT_W'(65536);
            safe_radius_reg  <= RADIUS_W'(131072);
            radius_sq_reg    <= SQ_W'(131072) * SQ_W'(131072);
            stale_limit_reg  <= TIME_W'(1000);
            skip_takeoff_reg <= 1'b0;
            land_enable_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOVER_HEIGHT: hover_height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_SAFE_RADIUS:
                begin
                    safe_radius_reg <= cfg_data[RADIUS_W-1:0];
                    radius_sq_reg   <= {{RADIUS_W{1'b0}}, cfg_data[RADIUS_W-1:0]}
                                     * {{RADIUS_W{1'b0}}, cfg_data[RADIUS_W-1:0]};
                end
                CFG_STALE_LIMIT:  stale_limit_reg  <= cfg_data[TIME_W-1:0];
                CFG_SKIP_TAKEOFF: skip_takeoff_reg <= cfg_data[0];
                CFG_LAND_ENABLE:  land_enable_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_data_reg <= s_tdata;
            s1_func_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ST_STARTUP;
            pose_ss_reg   <= SS_INIT;
            ob_ss_reg     <= SS_INIT;
            sp_ss_reg     <= SS_INIT;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                stamp_reg[i]   <= '0;
                tgt_pos_reg[i] <= '0;
                cur_pos_reg[i] <= '0;
                sav_pos_reg[i] <= '0;
                lpp_reg[i]     <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                tgt_q_reg[i] <= '0;
                cur_q_reg[i] <= '0;
                sav_q_reg[i] <= '0;
            end
        end
        else
        begin
            mode_reg      <= mode_next;
            pose_ss_reg   <= pose_ss_next;
            ob_ss_reg     <= ob_ss_next;
            sp_ss_reg     <= sp_ss_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                stamp_reg[i]   <= stamp_next[i];
                tgt_pos_reg[i] <= tgt_pos_next[i];
                cur_pos_reg[i] <= cur_pos_next[i];
                lpp_reg[i]     <= lpp_next[i];
                if (fire)
                begin
                    sav_pos_reg[i] <= sav_pos_next[i];
                end
            end
            for (int i = 0; i < 4; i++)
            begin
                tgt_q_reg[i] <= tgt_q_next[i];
                cur_q_reg[i] <= cur_q_next[i];
                if (fire)
                begin
                    sav_q_reg[i] <= sav_q_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_pub_reg  <= out_pub_next;
    end

    // a forced landing word always reports startup and never a takeoff
    a_forced_land: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |->
            (m_tdata[OUT_BITS-CMD_W-1 -: FSM_W] == FSM_STARTUP)
            && (m_tdata[OUT_BITS-1 -: CMD_W] != CMD_TAKEOFF))
        else $error("forced landing word malformed");

    // takeoff is only issued on the way into hover
    a_takeoff_hover: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[OUT_BITS-1 -: CMD_W] == CMD_TAKEOFF)) |->
            (m_tdata[OUT_BITS-CMD_W-1 -: FSM_W] == FSM_HOVER))
        else $error("takeoff outside hover");

    // each processed publish tick advances the sequence by one
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (s1_func_reg == FN_PUBLISH)) |=> (tick_reg == $past(tick_reg) + 1'b1))
        else $error("sequence did not advance");

    // a full input stage behind a stalled result must refuse new words
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while stalled");

    // a publish result reflects the sequence count held before it
    a_pub_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (s1_func_reg == FN_PUBLISH)) |=>
            (m_tvalid && m_tuser[0] && (m_tdata[3*POS_W+4*QUAT_W +: TIME_W] == $past(tick_reg))))
        else $error("publish word sequence mismatch");

endmodule

// File: tb/flight_setpoint_supervisor_tb.sv
// Self-checking testbench for the flight setpoint supervisor stream block.
module flight_setpoint_supervisor_tb;
    import fss_pkg::*;

    // One input word with its selector on top; the low IN_BITS map straight onto s_tdata.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              offboard;
        logic [15:0]       qz, qy, qx, qw;
        logic [31:0]       pz, py, px;
        logic [31:0]       stamp;
        logic [31:0]       now_t;
    } fss_item_t;

    // One result: publish flag on top, then the low OUT_BITS of m_tdata.
    typedef struct packed {
        logic        pub;
        logic [1:0]  cmd;
        logic [1:0]  fsm;
        logic [31:0] seq;
        logic [15:0] qz, qy, qx, qw;
        logic [31:0] sz, sy, sx;
    } fss_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic [FUNC_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    flight_setpoint_supervisor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Supervisor copy: settings
    logic [30:0] hov_h;
    logic [30:0] radius;
    logic [31:0] stale_lim;
    logic        skip_to;
    logic        land_en;

    // Supervisor copy: state
    logic [1:0]  sup_mode;
    stream_t     pose_st, ob_st, sp_st;
    logic [31:0] stamps [3];
    logic [31:0] tgt_pos [3];
    logic [31:0] cur_pos [3];
    logic [31:0] sav_pos [3];
    logic [31:0] pub_last [3];
    logic [15:0] tgt_q [4];
    logic [15:0] cur_q [4];
    logic [15:0] sav_q [4];
    logic [31:0] tick_cnt;

    fss_item_t   pending_words [$];
    fss_result_t results_due [$];
    fss_item_t   offered;
    int          fail_count = 0;

    // Stimulus generator state
    logic [31:0] fl_time;
    logic [31:0] cx, cy;
    logic        sp_feed;
    logic        idle_enable = 1'b1;
    logic        long_hold_req = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          sink_hold = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #1000000;
        $display("flight_setpoint_supervisor_tb failed");
        $finish;
    end

    function automatic logic fresh(logic [31:0] at, logic [31:0] st);
        logic [31:0] age;
        age = at - st;
        return age < stale_lim;
    endfunction

    function automatic logic [1:0] land_code();
        return land_en ? CMD_LAND : CMD_NONE;
    endfunction

    function automatic fss_item_t item_of(logic [2:0] f, logic [31:0] at, logic [31:0] st,
                                          logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic [15:0] q, logic ob);
        fss_item_t it;
        it.func = f;
        it.now_t = at;
        it.stamp = st;
        it.px = x;
        it.py = y;
        it.pz = z;
        it.qw = q;
        it.qx = q;
        it.qy = q;
        it.qz = q;
        it.offboard = ob;
        return it;
    endfunction

    function automatic fss_item_t rand_item();
        fss_item_t it;
        it.func = 3'($urandom_range(0, 7));
        it.now_t = $urandom;
        it.stamp = $urandom;
        it.px = $urandom;
        it.py = $urandom;
        it.pz = $urandom;
        it.qw = 16'($urandom);
        it.qx = 16'($urandom);
        it.qy = 16'($urandom);
        it.qz = 16'($urandom);
        it.offboard = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Advance the supervisor copy by one accepted word and queue what it must emit.
    function automatic void supervise_step(fss_item_t it);
        fss_result_t r;
        logic [31:0] pp [3];
        logic [15:0] pq [4];
        logic        ep_on, ep_off, ob_on, ob_off, sp_on, sp_off;
        logic [33:0] d, a;
        logic [67:0] sum, rr;
        logic        outside;
        r = '0;
        case (it.func)
            FN_POS_SP:
            begin
                sp_st = SS_ON;
                stamps[0] = it.stamp;
                tgt_pos = '{it.px, it.py, it.pz};
            end
            FN_ATT_SP:
            begin
                sp_st = SS_ON;
                stamps[1] = it.stamp;
                tgt_q = '{it.qw, it.qx, it.qy, it.qz};
            end
            FN_POSE:
            begin
                stamps[2] = it.stamp;
                cur_pos = '{it.px, it.py, it.pz};
                cur_q = '{it.qw, it.qx, it.qy, it.qz};
            end
            FN_MODE:
            begin
                if (it.offboard)
                    ob_st = SS_ON;
                else
                    ob_st = SS_OFF;
            end
            FN_CHECKUP:
            begin
                if (!fresh(it.now_t, stamps[0]) && !fresh(it.now_t, stamps[1]))
                    sp_st = SS_OFF;
                if (fresh(it.now_t, stamps[2]))
                    pose_st = SS_ON;
                else
                    pose_st = SS_OFF;
                // Exact distance test: any axis beyond the radius fires outright.
                rr = 68'(radius);
                sum = '0;
                outside = 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    d = {{2{cur_pos[i][31]}}, cur_pos[i]} - {{2{pub_last[i][31]}}, pub_last[i]};
                    a = d[33] ? -d : d;
                    if (68'(a) > rr)
                        outside = 1'b1;
                    sum = sum + 68'(a) * 68'(a);
                end
                if (outside || sum > rr * rr)
                begin
                    sup_mode = FSM_STARTUP;
                    r.fsm = FSM_STARTUP;
                    r.cmd = land_code();
                    results_due.push_back(r);
                end
            end
            FN_PUBLISH:
            begin
                ep_on = pose_st == SS_ON;
                ep_off = pose_st == SS_OFF;
                ob_on = ob_st == SS_ON;
                ob_off = ob_st == SS_OFF;
                sp_on = sp_st == SS_ON;
                sp_off = sp_st == SS_OFF;
                if (sup_mode == FSM_ACTIVE)
                begin
                    sav_pos = cur_pos;
                    sav_q = cur_q;
                    pp = tgt_pos;
                    pq = tgt_q;
                end
                else
                begin
                    if (sup_mode == FSM_HOVER)
                        sav_pos[2] = {1'b0, hov_h};
                    else
                    begin
                        sav_pos = cur_pos;
                        sav_q = cur_q;
                        sav_pos[2] = '0;
                    end
                    pp = sav_pos;
                    pq = sav_q;
                end
                r.cmd = CMD_NONE;
                case (sup_mode)
                    FSM_STARTUP:
                    begin
                        if (ep_on && ob_off)
                            sup_mode = FSM_LINKED;
                    end
                    FSM_LINKED:
                    begin
                        if (ep_off)
                        begin
                            r.cmd = land_code();
                            sup_mode = FSM_STARTUP;
                        end
                        else if (ep_on && ob_on && sp_off)
                        begin
                            r.cmd = skip_to ? CMD_NONE : CMD_TAKEOFF;
                            sup_mode = FSM_HOVER;
                        end
                    end
                    FSM_HOVER:
                    begin
                        if (ep_off)
                        begin
                            r.cmd = land_code();
                            sup_mode = FSM_STARTUP;
                        end
                        else if (ep_on && ob_off)
                        begin
                            r.cmd = land_code();
                            sup_mode = FSM_LINKED;
                        end
                        else if (ep_on && ob_on && sp_on)
                            sup_mode = FSM_ACTIVE;
                    end
                    default:
                    begin
                        if (ep_on && ob_off)
                        begin
                            r.cmd = land_code();
                            sup_mode = FSM_LINKED;
                        end
                        else if (ep_on && ob_on && sp_off)
                            sup_mode = FSM_HOVER;
                        else if (ep_off)
                        begin
                            r.cmd = land_code();
                            sup_mode = FSM_STARTUP;
                        end
                    end
                endcase
                pub_last = pp;
                r.pub = 1'b1;
                r.sx = pp[0];
                r.sy = pp[1];
                r.sz = pp[2];
                r.qw = pq[0];
                r.qx = pq[1];
                r.qy = pq[2];
                r.qz = pq[3];
                r.seq = tick_cnt;
                r.fsm = sup_mode;
                results_due.push_back(r);
                tick_cnt = tick_cnt + 1;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_HOVER_HEIGHT: hov_h = val[30:0];
            CFG_SAFE_RADIUS:  radius = val[30:0];
            CFG_STALE_LIMIT:  stale_lim = val;
            CFG_SKIP_TAKEOFF: skip_to = val[0];
            CFG_LAND_ENABLE:  land_en = val[0];
            default:
            begin
            end
        endcase
    endtask

    // Wait for the sender to empty, every result to arrive, then the pipeline to go quiet.
    task automatic settle();
        @(negedge clk);
        while (pending_words.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Sender: present the next pending word once the current one is taken.
    always @(posedge clk)
    begin : feed_proc
        fss_item_t nxt;
        if (s_tvalid && s_tready)
            supervise_step(offered);
        if (!s_tvalid || s_tready)
        begin
            if (src_gap != 0)
            begin
                src_gap = src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                nxt = pending_words.pop_front();
                offered <= nxt;
                s_tdata <= IN_W'(nxt[IN_BITS-1:0]);
                s_tuser <= nxt.func;
                s_tvalid <= 1'b1;
                if (idle_enable && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 8);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random back-pressure plus one long hold on request.
    always @(posedge clk)
    begin : sink_proc
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            sink_hold = 300;
        end
        if (sink_hold != 0)
        begin
            sink_hold = sink_hold - 1;
            m_tready <= 1'b0;
        end
        else if (sink_gap != 0)
        begin
            sink_gap = sink_gap - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_enable && $urandom_range(0, 5) == 0)
                sink_gap = $urandom_range(1, 8);
        end
    end

    always @(posedge clk)
    begin : watch_proc
        fss_result_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[OUT_BITS-1:0]};
            if (results_due.size() == 0)
            begin
                $error("result word with nothing predicted: %h", got);
                fail_count++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("publish_valid", 32'(want.pub), 32'(got.pub));
                check_field("sp_x", want.sx, got.sx);
                check_field("sp_y", want.sy, got.sy);
                check_field("sp_z", want.sz, got.sz);
                check_field("sp_qw", 32'(want.qw), 32'(got.qw));
                check_field("sp_qx", 32'(want.qx), 32'(got.qx));
                check_field("sp_qy", 32'(want.qy), 32'(got.qy));
                check_field("sp_qz", 32'(want.qz), 32'(got.qz));
                check_field("sequence_res", want.seq, got.seq);
                check_field("fsm_state", 32'(want.fsm), 32'(got.fsm));
                check_field("command", 32'(want.cmd), 32'(got.cmd));
            end
        end
    end

    initial
    begin : stim_proc
        fss_item_t   it;
        int unsigned pick, span, step;
        logic [31:0] cfg_v [5];
        hov_h = 31'd65536;
        radius = 31'd131072;
        stale_lim = 32'd1000;
        skip_to = 1'b0;
        land_en = 1'b1;
        sup_mode = FSM_STARTUP;
        pose_st = SS_INIT;
        ob_st = SS_INIT;
        sp_st = SS_INIT;
        stamps = '{default: '0};
        tgt_pos = '{default: '0};
        cur_pos = '{default: '0};
        sav_pos = '{default: '0};
        pub_last = '{default: '0};
        tgt_q = '{default: '0};
        cur_q = '{default: '0};
        sav_q = '{default: '0};
        tick_cnt = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk startup -> linked -> hover -> active, then a forced landing and odd codes.
        pending_words.push_back(item_of(FN_PUBLISH, 0, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_CHECKUP, 5, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_MODE, 0, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_PUBLISH, 10, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_POSE, 0, 2000, 100, -100, 0, 16'h4000, 1'b0));
        pending_words.push_back(item_of(FN_CHECKUP, 2000, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_MODE, 0, 0, 0, 0, 0, 16'h0000, 1'b1));
        pending_words.push_back(item_of(FN_PUBLISH, 2010, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_PUBLISH, 2020, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_POS_SP, 0, 2050, 200, 0, 65536, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_ATT_SP, 0, 2050, 0, 0, 0, 16'hC000, 1'b0));
        pending_words.push_back(item_of(FN_PUBLISH, 2060, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_PUBLISH, 2070, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_CHECKUP, 2100, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_POSE, 0, 32'hFFFF_FFF0, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 1'b0));
        pending_words.push_back(item_of(FN_CHECKUP, 32'h10, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(3'd6, '1, '1, '1, '1, '1, 16'hFFFF, 1'b1));
        pending_words.push_back(item_of(3'd7, '1, '1, '1, '1, '1, 16'hFFFF, 1'b1));
        pending_words.push_back(item_of(FN_POSE, 0, 0, 0, 0, 0, 16'h8000, 1'b0));
        pending_words.push_back(item_of(FN_CHECKUP, '1, 0, 0, 0, 0, 16'h0000, 1'b0));
        pending_words.push_back(item_of(FN_PUBLISH, '1, '1, '1, '1, '1, 16'hFFFF, 1'b1));
        pending_words.push_back(item_of(FN_POS_SP, '1, '1, 32'h8000_0000, '1,
                                        32'h8000_0000, 16'hFFFF, 1'b1));
        pending_words.push_back(item_of(FN_MODE, '1, '1, '1, '1, '1, 16'hFFFF, 1'b0));
        pending_words.push_back(item_of(FN_PUBLISH, 0, 0, 0, 0, 0, 16'h0000, 1'b0));
        settle();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                1: cfg_v = '{32'd0, 32'd0, 32'd1, 32'd1, 32'd0};
                2: cfg_v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1};
                3, 4: cfg_v = '{$urandom_range(0, 1 << 18), $urandom_range(1 << 15, 1 << 19),
                                $urandom_range(10, 5000), $urandom_range(0, 1),
                                $urandom_range(0, 1)};
                5: cfg_v = '{32'd65536, 32'd131072, 32'd1000, 32'd1, 32'd0};
                default: cfg_v = '{32'd65536, 32'd131072, 32'd1000, 32'd0, 32'd1};
            endcase
            write_reg(CFG_HOVER_HEIGHT, cfg_v[0]);
            write_reg(CFG_SAFE_RADIUS, cfg_v[1]);
            write_reg(CFG_STALE_LIMIT, cfg_v[2]);
            write_reg(CFG_SKIP_TAKEOFF, cfg_v[3]);
            write_reg(CFG_LAND_ENABLE, cfg_v[4]);
            @(posedge clk);
            cfg_we <= 1'b0;

            cx = $urandom_range(0, 1 << 20) - (1 << 19);
            cy = $urandom_range(0, 1 << 20) - (1 << 19);
            fl_time = $urandom;
            sp_feed = 1'b1;
            span = (radius > 31'd16777216) ? 16777216 : 32'(radius);
            step = (stale_lim > 32'd4096) ? 1024 : stale_lim / 4;

            for (int c = 0; c < 4; c++)
            begin
                @(negedge clk);
                while (pending_words.size() > 4)
                    @(negedge clk);
                idle_enable = (ph == 6) ? 1'b0 : ($urandom_range(0, 4) != 0);
                // Hold the receiver off while this chunk streams in.
                if (ph == 1 && c == 1)
                    long_hold_req = 1'b1;
                repeat (53)
                begin
                    if ($urandom_range(0, 1) == 1)
                        fl_time = fl_time + $urandom_range(0, step);
                    // Jump far ahead now and then so every stream goes stale.
                    if ($urandom_range(0, 39) == 0)
                        fl_time = fl_time + stale_lim + $urandom_range(0, 1000);
                    if ($urandom_range(0, 19) == 0)
                        sp_feed = !sp_feed;
                    it = rand_item();
                    it.px = cx + $urandom_range(0, span) - span / 2;
                    it.py = cy + $urandom_range(0, span) - span / 2;
                    it.pz = hov_h + $urandom_range(0, span) - span / 2;
                    it.stamp = fl_time - $urandom_range(0, step);
                    it.now_t = fl_time;
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                        it = rand_item();
                    else if (pick < 30)
                        it.func = FN_POSE;
                    else if (pick < 42)
                        it.func = sp_feed ? FN_POS_SP : FN_PUBLISH;
                    else if (pick < 47)
                        it.func = sp_feed ? FN_ATT_SP : FN_CHECKUP;
                    else if (pick < 55)
                    begin
                        it.func = FN_MODE;
                        it.offboard = ($urandom_range(0, 3) != 0);
                    end
                    else if (pick < 80)
                        it.func = FN_PUBLISH;
                    else
                        it.func = FN_CHECKUP;
                    pending_words.push_back(it);
                end
            end
            settle();
        end

        if (fail_count == 0)
            $display("flight_setpoint_supervisor_tb passed");
        else
            $display("flight_setpoint_supervisor_tb failed");
        $finish;
    end

endmodule

// File: filelist.f
design/fss_pkg.sv
design/flight_setpoint_supervisor.sv
tb/flight_setpoint_supervisor_tb.sv
